// File: hw/rtl/banked_register_file_defines.svh
// Assertion macros for the banked register file.
// Included by the top level only; needs clk and rst_n in scope.
`ifndef BANKED_REGISTER_FILE_DEFINES_SVH
`define BANKED_REGISTER_FILE_DEFINES_SVH

`ifndef ASSERT_OFF
// condition must hold at every clock edge out of reset
`define BRF_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: %m");
// antecedent implies consequent in the same cycle
`define BRF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: %m");
// antecedent implies consequent in the next cycle
`define BRF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: %m");
`else
`define BRF_ASSERT(lbl, cond)
`define BRF_ASSERT_IMP(lbl, ante, cons)
`define BRF_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: hw/rtl/brf_pkg.sv
// Types, constants and cell mapping for the banked register file.
// No dependencies; imported by the controller, datapath and top level.
package brf_pkg;

  // request kinds carried on in_tuser
  typedef enum logic [2:0] {
    REQ_RD_REG  = 3'd0,
    REQ_WR_REG  = 3'd1,
    REQ_RD_USER = 3'd2,
    REQ_WR_USER = 3'd3,
    REQ_RD_CPSR = 3'd4,
    REQ_WR_CPSR = 3'd5,
    REQ_RD_SPSR = 3'd6,
    REQ_WR_SPSR = 3'd7
  } brf_req_t;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } brf_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;   // capture the incoming request
    logic exec;   // perform the access and register the result
  } brf_cmd_t;

  // processor modes (CPSR[4:0])
  localparam logic [4:0] MODE_USR = 5'h10;
  localparam logic [4:0] MODE_FIQ = 5'h11;
  localparam logic [4:0] MODE_IRQ = 5'h12;
  localparam logic [4:0] MODE_SVC = 5'h13;
  localparam logic [4:0] MODE_ABT = 5'h17;
  localparam logic [4:0] MODE_UND = 5'h1B;
  localparam logic [4:0] MODE_SYS = 5'h1F;

  // bank slots of the modes that own an SPSR
  localparam logic [2:0] SLOT_FIQ = 3'd0;
  localparam logic [2:0] SLOT_IRQ = 3'd1;
  localparam logic [2:0] SLOT_SVC = 3'd2;
  localparam logic [2:0] SLOT_ABT = 3'd3;
  localparam logic [2:0] SLOT_UND = 3'd4;
  localparam logic [2:0] NO_SLOT  = 3'd5;
  localparam int         NUM_SPSR = 5;

  // flat cell layout: user r0-r15, FIQ r8-r12, then r13/r14 per slot
  localparam int         NUM_CELLS      = 31;
  localparam logic [4:0] CELL_BANK_BASE = 5'd21;
  localparam logic [31:0] CPSR_RESET    = 32'h0000_001F;

  function automatic logic [2:0] mode_slot(input logic [4:0] m);
    logic [2:0] s;
    unique case (m)
      MODE_FIQ: s = SLOT_FIQ;
      MODE_IRQ: s = SLOT_IRQ;
      MODE_SVC: s = SLOT_SVC;
      MODE_ABT: s = SLOT_ABT;
      MODE_UND: s = SLOT_UND;
      default:  s = NO_SLOT;
    endcase
    return s;
  endfunction

  // physical cell of logical register idx as seen from a bank slot
  function automatic logic [4:0] cell_addr(input logic [2:0] slot, input logic [3:0] idx);
    logic [4:0] a;
    a = {1'b0, idx};
    if (slot != NO_SLOT) begin
      if (idx == 4'd13 || idx == 4'd14) begin
        // r13 has idx[0] set, r14 clear
        a = 5'(CELL_BANK_BASE + {1'b0, slot, 1'b0} + {4'b0, ~idx[0]});
      end else if (slot == SLOT_FIQ && idx >= 4'd8 && idx <= 4'd12) begin
        a = {2'b10, idx[2:0]};
      end
    end
    return a;
  endfunction

endpackage

// File: hw/rtl/brf_ctrl.sv
// Controller state machine of the banked register file.
// Depends on brf_pkg; drives handshakes and datapath commands.
module brf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output brf_pkg::brf_cmd_t cmd
);
  import brf_pkg::*;

  brf_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    cmd        = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      ST_RESP: begin
        out_tvalid = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/brf_datapath.sv
// Datapath of the banked register file: register cells, CPSR, SPSRs.
// Depends on brf_pkg; sequenced by brf_ctrl through brf_cmd_t.
module brf_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  brf_pkg::brf_cmd_t cmd,
  input  logic [2:0]        req_type,
  input  logic [3:0]        reg_index,
  input  logic [31:0]       write_value,
  output logic [31:0]       read_data,
  output logic              spsr_missing,
  output logic [4:0]        current_mode,
  output logic              privileged,
  output logic              mode_has_spsr
);
  import brf_pkg::*;

  // captured request
  brf_req_t    req_r;
  logic [3:0]  idx_r;
  logic [31:0] val_r;

  // architectural state
  logic [31:0] cells_r [NUM_CELLS];
  logic [31:0] spsr_r  [NUM_SPSR];
  logic [31:0] cpsr_r;

  // result registers
  logic [31:0] rd_r;
  logic        missing_r;
  logic [4:0]  mode_r;

  logic [4:0]  cur_mode;
  logic [2:0]  slot;
  logic        user_acc;
  logic [4:0]  addr;
  logic [31:0] cell_q;
  logic [2:0]  spsr_sel;
  logic        cell_we;
  logic        spsr_we;
  logic        cpsr_we;
  logic [31:0] rd_nxt;
  logic        missing_nxt;
  logic [4:0]  mode_nxt;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= brf_req_t'(req_type);
      idx_r <= reg_index;
      val_r <= write_value;
    end
  end

  // bank selection and single read port
  assign cur_mode = cpsr_r[4:0];
  assign slot     = mode_slot(cur_mode);
  assign user_acc = (req_r == REQ_RD_USER) || (req_r == REQ_WR_USER);
  assign addr     = user_acc ? {1'b0, idx_r} : cell_addr(slot, idx_r);
  assign cell_q   = cells_r[addr];
  assign spsr_sel = (slot == NO_SLOT) ? 3'd0 : slot;

  // access decode
  always_comb begin
    rd_nxt      = '0;
    missing_nxt = 1'b0;
    cell_we     = 1'b0;
    spsr_we     = 1'b0;
    cpsr_we     = 1'b0;
    case (req_r)
      REQ_RD_REG, REQ_RD_USER: rd_nxt = cell_q;
      REQ_WR_REG:  cell_we = 1'b1;
      REQ_WR_USER: cell_we = (cur_mode == MODE_USR);
      REQ_RD_CPSR: rd_nxt = cpsr_r;
      REQ_WR_CPSR: cpsr_we = 1'b1;
      REQ_RD_SPSR: begin
        if (slot != NO_SLOT) begin
          rd_nxt = spsr_r[spsr_sel];
        end else begin
          rd_nxt      = '1;
          missing_nxt = 1'b1;
        end
      end
      REQ_WR_SPSR: begin
        if (slot != NO_SLOT) spsr_we = 1'b1;
        else missing_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  // mode after the access
  assign mode_nxt = cpsr_we ? val_r[4:0] : cur_mode;

  // state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CELLS; i++) cells_r[i] <= '0;
      for (int i = 0; i < NUM_SPSR; i++) spsr_r[i] <= '0;
      cpsr_r <= CPSR_RESET;
    end else if (cmd.exec) begin
      if (cell_we) cells_r[addr] <= val_r;
      if (spsr_we) spsr_r[spsr_sel] <= val_r;
      if (cpsr_we) cpsr_r <= val_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_r      <= rd_nxt;
      missing_r <= missing_nxt;
      mode_r    <= mode_nxt;
    end
  end

  assign read_data     = rd_r;
  assign spsr_missing  = missing_r;
  assign current_mode  = mode_r;
  assign privileged    = (mode_r != MODE_USR);
  assign mode_has_spsr = (mode_r != MODE_USR) && (mode_r != MODE_SYS);

endmodule

// File: hw/rtl/banked_register_file.sv
// Banked register file, ARMv5 style, one access per request.
// Each request runs through the controller sequence idle -> execute -> respond,
// and a new request is taken only back in idle, once the result has been taken;
// a stalled result holds the next request off.
// Reset (synchronous, rst_n low): all registers and SPSRs cleared, CPSR = 0x1F.
// Depends on brf_pkg, brf_ctrl, brf_datapath and the defines header.
`include "banked_register_file_defines.svh"

module banked_register_file (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [3:0] reg_index, [35:4] write_value, rest zero
  input  logic [2:0]  in_tuser,   // [2:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] read_data
  output logic [7:0]  out_tuser   // [0] spsr_missing, [5:1] current_mode,
                                  // [6] privileged, [7] mode_has_spsr
);
  import brf_pkg::*;

  brf_cmd_t cmd;
  logic     spsr_missing;
  logic [4:0] current_mode;
  logic     privileged;
  logic     mode_has_spsr;

  // sequencing
  brf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // storage and access logic
  brf_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .req_type      (in_tuser),
    .reg_index     (in_tdata[3:0]),
    .write_value   (in_tdata[35:4]),
    .read_data     (out_tdata),
    .spsr_missing  (spsr_missing),
    .current_mode  (current_mode),
    .privileged    (privileged),
    .mode_has_spsr (mode_has_spsr)
  );

  assign out_tuser = {mode_has_spsr, privileged, current_mode, spsr_missing};

  // checks
  `BRF_ASSERT(a_one_request_in_flight, !(in_tready && out_tvalid))
  `BRF_ASSERT_NXT(a_accept_blocks_input, in_tvalid && in_tready, !in_tready && !out_tvalid)
  `BRF_ASSERT_NXT(a_result_clears, out_tvalid && out_tready, !out_tvalid)
  `BRF_ASSERT_IMP(a_user_has_no_spsr, out_tvalid && !privileged, !mode_has_spsr)

endmodule
